// ----- rtl/nlc_pkg.sv -----
package nlc_pkg;

  // Signed range of the integer result; the magnitude register holds up to 2^(VALUE_WIDTH-1).
  localparam int VALUE_WIDTH = 32;
  localparam int MAG_W       = VALUE_WIDTH;
  localparam int PROD_W      = MAG_W + 4;

  localparam logic [MAG_W-1:0] MAG_LIMIT     = MAG_W'(1) << (MAG_W - 1);
  localparam logic [MAG_W-1:0] MAG_LIMIT_POS = MAG_LIMIT - MAG_W'(1);

  localparam int INT_W = 32;

  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_INT  = 2'd1,
    CLASS_REAL = 2'd2
  } number_class_t;

  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

endpackage

// ----- rtl/numeric_literal_classifier_unit.sv -----
// Decimal number literal classifier.
// Byte channel: char_byte / last_byte under byte_valid / byte_ready. One transfer
// carries one character of a token; last_byte marks its final character.
// Result channel: number_class / int_value / int_overflow under result_valid /
// result_ready. Exactly one result leaves per token, for its final character.
// Path: a byte is held in the input register, then the parse state advances
// and, on the final byte, the result register loads; a final byte waits in
// the input register while the result register is still full.
// Throughput: one byte per clock, but a final byte stalls while the result
// register is full; the parse step between the input register and the result
// register is a multiply-by-ten add and a compare on the magnitude.
// Reset (rst, synchronous): drop any partial token and any pending result; the
// next byte starts a new token.
// Receiver stall: the result register holds its value while result_ready is
// low; bytes that are not final keep flowing, and a final byte waits in the
// input register until the result register frees up, which then back-pressures
// byte_ready.
module numeric_literal_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_byte,
  input  logic        last_byte,
  input  logic        byte_valid,
  output logic        byte_ready,
  output logic [1:0]  number_class,
  output logic signed [31:0] int_value,
  output logic        int_overflow,
  output logic        result_valid,
  input  logic        result_ready
);

  localparam int MW = nlc_pkg::MAG_W;
  localparam int PW = nlc_pkg::PROD_W;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_adv;
  logic       out_free;

  // Parse state.
  logic          at_first_byte, at_first_byte_next;
  logic          is_negative, is_negative_next;
  logic          seen_dot, seen_dot_next;
  logic          seen_exponent, seen_exponent_next;
  logic          mantissa_digit_seen, mantissa_digit_seen_next;
  logic          exponent_digit_seen, exponent_digit_seen_next;
  logic          rejected, rejected_next;
  logic [MW-1:0] magnitude, magnitude_next;
  logic          too_large, too_large_next;

  logic          is_digit;
  logic          is_sign;
  logic [3:0]    digit;
  logic [PW-1:0] prod;

  logic          ok;
  logic          fits;
  logic [63:0]   mag_ext;
  logic [63:0]   value_ext;
  logic [1:0]    class_calc;
  logic [31:0]   value_calc;
  logic          ovf_calc;

  // A non-final byte never produces a result, so it always advances.
  assign out_free   = !result_valid || result_ready;
  assign s1_adv     = s1_valid && (!s1_last || out_free);
  assign byte_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      s1_char <= char_byte;
      s1_last <= last_byte;
    end
  end

  // Character decode and magnitude step.
  assign is_digit = (s1_char >= nlc_pkg::CH_ZERO) && (s1_char <= nlc_pkg::CH_NINE);
  assign is_sign  = (s1_char == nlc_pkg::CH_PLUS) || (s1_char == nlc_pkg::CH_MINUS);
  assign digit    = s1_char[3:0];
  assign prod     = (PW'(magnitude) << 3) + (PW'(magnitude) << 1) + PW'(digit);

  always_comb begin
    at_first_byte_next       = 1'b0;
    is_negative_next         = is_negative;
    seen_dot_next            = seen_dot;
    seen_exponent_next       = seen_exponent;
    mantissa_digit_seen_next = mantissa_digit_seen;
    exponent_digit_seen_next = exponent_digit_seen;
    rejected_next            = rejected;
    magnitude_next           = magnitude;
    too_large_next           = too_large;

    if (s1_char >= nlc_pkg::CH_HIGH) begin
      rejected_next = 1'b1;
    end else if (at_first_byte && is_sign) begin
      is_negative_next = (s1_char == nlc_pkg::CH_MINUS);
    end else if (is_digit) begin
      if (seen_exponent) begin
        exponent_digit_seen_next = 1'b1;
      end else begin
        mantissa_digit_seen_next = 1'b1;
        // Stop growing once the next step would pass the limit.
        if (!too_large) begin
          if (prod <= PW'(nlc_pkg::MAG_LIMIT)) begin
            magnitude_next = prod[MW-1:0];
          end else begin
            too_large_next = 1'b1;
          end
        end
      end
    end else if (s1_char == nlc_pkg::CH_DOT && !seen_dot && !seen_exponent) begin
      seen_dot_next = 1'b1;
    end else if ((s1_char == nlc_pkg::CH_E_LO || s1_char == nlc_pkg::CH_E_UP)
                 && !seen_exponent) begin
      seen_exponent_next = 1'b1;
    end else if (is_sign && seen_exponent) begin
      // Exponent sign: accept without effect.
    end else begin
      rejected_next = 1'b1;
    end
  end

  // Classify from the state as it stands after the final byte.
  assign ok = !rejected_next && mantissa_digit_seen_next &&
              (!seen_exponent_next || exponent_digit_seen_next);
  assign fits = !too_large_next &&
                (is_negative_next ? (magnitude_next <= nlc_pkg::MAG_LIMIT)
                                  : (magnitude_next <= nlc_pkg::MAG_LIMIT_POS));
  assign mag_ext   = 64'(magnitude_next);
  assign value_ext = is_negative_next ? (64'd0 - mag_ext) : mag_ext;

  always_comb begin
    class_calc = nlc_pkg::CLASS_NONE;
    value_calc = '0;
    ovf_calc   = 1'b0;
    if (ok) begin
      if (seen_dot_next || seen_exponent_next) begin
        class_calc = nlc_pkg::CLASS_REAL;
      end else if (fits) begin
        class_calc = nlc_pkg::CLASS_INT;
        value_calc = value_ext[31:0];
      end else begin
        class_calc = nlc_pkg::CLASS_REAL;
        ovf_calc   = 1'b1;
      end
    end
  end

  // Advance the parse state; clear it after each final byte.
  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_last)) begin
      at_first_byte       <= 1'b1;
      is_negative         <= 1'b0;
      seen_dot            <= 1'b0;
      seen_exponent       <= 1'b0;
      mantissa_digit_seen <= 1'b0;
      exponent_digit_seen <= 1'b0;
      rejected            <= 1'b0;
      magnitude           <= '0;
      too_large           <= 1'b0;
    end else if (s1_adv) begin
      at_first_byte       <= at_first_byte_next;
      is_negative         <= is_negative_next;
      seen_dot            <= seen_dot_next;
      seen_exponent       <= seen_exponent_next;
      mantissa_digit_seen <= mantissa_digit_seen_next;
      exponent_digit_seen <= exponent_digit_seen_next;
      rejected            <= rejected_next;
      magnitude           <= magnitude_next;
      too_large           <= too_large_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      number_class <= class_calc;
      int_value    <= value_calc;
      int_overflow <= ovf_calc;
    end
  end

endmodule

// ----- rtl/nlc_checker.sv -----
module nlc_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_ready,
  input logic [1:0]  number_class,
  input logic [31:0] int_value,
  input logic        int_overflow,
  input logic        result_valid,
  input logic        result_ready
);

  // No result survives reset, and the byte side is open right after it.
  a_reset_clears: assert property (@(posedge clk) rst |=> (!result_valid && byte_ready))
    else $error("result_valid high or byte_ready low after reset");

  // Class code stays within its defined values.
  a_class_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (number_class == nlc_pkg::CLASS_NONE ||
                      number_class == nlc_pkg::CLASS_INT ||
                      number_class == nlc_pkg::CLASS_REAL))
    else $error("undefined number_class");

  // Overflow is reported only as real.
  a_ovf_real: assert property (@(posedge clk) disable iff (rst)
    (result_valid && int_overflow) |-> number_class == nlc_pkg::CLASS_REAL)
    else $error("int_overflow without real class");

  // Value is zero unless the class is integer.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && number_class != nlc_pkg::CLASS_INT) |-> int_value == 32'd0)
    else $error("nonzero int_value for non-integer class");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(number_class) && $stable(int_value) &&
       $stable(int_overflow)))
    else $error("stalled result changed");

endmodule

bind numeric_literal_classifier_unit nlc_checker u_nlc_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_ready   (byte_ready),
  .number_class (number_class),
  .int_value    (int_value),
  .int_overflow (int_overflow),
  .result_valid (result_valid),
  .result_ready (result_ready)
);

// ----- test/numeric_literal_classifier_unit_tb.sv -----
module numeric_literal_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Give up long after the slowest legal run would have ended.
  localparam int LIMIT = 1_000_000;
  // Cycles to wait after the last result for anything unexpected to show up.
  localparam int DRAIN = 16;
  localparam int RANDOM_BYTES = 2000;
  localparam int N_ROWS = 25;

  // One result transfer as the block presents it.
  typedef struct packed {
    nlc_pkg::number_class_t    cls;
    logic [nlc_pkg::INT_W-1:0] val;
    logic                      ovf;
  } lit_result_t;

  // One byte transfer; a row of the directed table may carry a typed-in result
  // on its final byte, which then stands in for the predicted one.
  typedef struct {
    logic [7:0]  ch;
    logic        last;
    bit          typed;
    lit_result_t want;
  } byte_item_t;

  // One row of the directed table: text, then an optional raw byte (extra < 0
  // means none), and the typed-in result where typed is set.
  typedef struct {
    string                     text;
    int                        extra;
    bit                        typed;
    nlc_pkg::number_class_t    cls;
    logic [nlc_pkg::INT_W-1:0] val;
    logic                      ovf;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic [7:0]       char_byte;
  logic             last_byte;
  logic             byte_valid;
  logic             byte_ready;
  logic [1:0]       number_class;
  logic signed [31:0] int_value;
  logic             int_overflow;
  logic             result_valid;
  logic             result_ready;

  numeric_literal_classifier_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .char_byte    (char_byte),
    .last_byte    (last_byte),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .number_class (number_class),
    .int_value    (int_value),
    .int_overflow (int_overflow),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Whole byte stream, built before the run starts; the monitor walks it by its
  // own index so it never races the driver.
  byte_item_t  byte_stream[$];
  logic [7:0]  tok_buf[$];
  lit_result_t pending_results[$];
  dir_row_t    dir_rows[N_ROWS];
  int          accepted_bytes = 0;
  int          error_count = 0;
  int          cycles = 0;

  // Parse state of the token in flight, mirrored from the block's behavior.
  logic                      tok_first;
  logic                      tok_neg;
  logic                      tok_dot;
  logic                      tok_exp;
  logic                      tok_mant;
  logic                      tok_expdig;
  logic                      tok_bad;
  logic [nlc_pkg::MAG_W-1:0] tok_mag;
  logic                      tok_big;

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Drop the token state back to its start-of-token values.
  task automatic clear_token();
    tok_first  = 1'b1;
    tok_neg    = 1'b0;
    tok_dot    = 1'b0;
    tok_exp    = 1'b0;
    tok_mant   = 1'b0;
    tok_expdig = 1'b0;
    tok_bad    = 1'b0;
    tok_mag    = '0;
    tok_big    = 1'b0;
  endtask

  // Advance the token state by one accepted byte; on the final byte, hand back
  // the classification and start a fresh token.
  task automatic classify_byte(input logic [7:0] c, input logic last,
                               output bit done, output lit_result_t res);
    logic                      first;
    logic                      ok;
    logic                      fits;
    logic [nlc_pkg::MAG_W-1:0] digit;
    first     = tok_first;
    tok_first = 1'b0;
    done      = 1'b0;
    res       = '{cls: nlc_pkg::CLASS_NONE, val: '0, ovf: 1'b0};

    if (c >= nlc_pkg::CH_HIGH) begin
      tok_bad = 1'b1;
    end else if (first && (c == nlc_pkg::CH_PLUS || c == nlc_pkg::CH_MINUS)) begin
      tok_neg = (c == nlc_pkg::CH_MINUS);
    end else if (c >= nlc_pkg::CH_ZERO && c <= nlc_pkg::CH_NINE) begin
      if (tok_exp) begin
        tok_expdig = 1'b1;
      end else begin
        digit    = nlc_pkg::MAG_W'(c - nlc_pkg::CH_ZERO);
        tok_mant = 1'b1;
        // Saturate: once past the limit, stop accumulating and hold the flag.
        if (!tok_big) begin
          if (tok_mag <= (nlc_pkg::MAG_LIMIT - digit) / nlc_pkg::MAG_W'(10))
            tok_mag = tok_mag * nlc_pkg::MAG_W'(10) + digit;
          else
            tok_big = 1'b1;
        end
      end
    end else if (c == nlc_pkg::CH_DOT && !tok_dot && !tok_exp) begin
      tok_dot = 1'b1;
    end else if ((c == nlc_pkg::CH_E_LO || c == nlc_pkg::CH_E_UP) && !tok_exp) begin
      tok_exp = 1'b1;
    end else if ((c == nlc_pkg::CH_PLUS || c == nlc_pkg::CH_MINUS) && tok_exp) begin
      // exponent signs go through wherever they sit
    end else begin
      tok_bad = 1'b1;
    end

    if (last) begin
      done = 1'b1;
      ok   = !tok_bad && tok_mant && (!tok_exp || tok_expdig);
      if (ok) begin
        if (tok_dot || tok_exp) begin
          res.cls = nlc_pkg::CLASS_REAL;
        end else begin
          fits = !tok_big && (tok_neg ? (tok_mag <= nlc_pkg::MAG_LIMIT)
                                      : (tok_mag <= nlc_pkg::MAG_LIMIT_POS));
          if (fits) begin
            res.cls = nlc_pkg::CLASS_INT;
            res.val = nlc_pkg::INT_W'(tok_neg ? -tok_mag : tok_mag);
          end else begin
            res.cls = nlc_pkg::CLASS_REAL;
            res.ovf = 1'b1;
          end
        end
      end
      clear_token();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++)
      tok_buf.push_back(s[i]);
  endtask

  task automatic add_digits(int n);
    for (int i = 0; i < n; i++)
      tok_buf.push_back(nlc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_sign();
    case ($urandom_range(0, 3))
      0: tok_buf.push_back(nlc_pkg::CH_PLUS);
      1: tok_buf.push_back(nlc_pkg::CH_MINUS);
      default: ;
    endcase
  endtask

  // Move the token in tok_buf onto the byte stream, marking its final byte.
  task automatic emit_token(bit typed, lit_result_t want);
    byte_item_t item;
    foreach (tok_buf[i]) begin
      item.ch    = tok_buf[i];
      item.last  = (i == tok_buf.size() - 1);
      item.typed = typed && item.last;
      item.want  = want;
      byte_stream.push_back(item);
    end
    tok_buf.delete();
  endtask

  // One directed row: text, then an optional raw byte (extra < 0 means none).
  task automatic add_row(string text, int extra, bit typed, nlc_pkg::number_class_t cls,
                         logic [nlc_pkg::INT_W-1:0] val, logic ovf);
    lit_result_t want;
    want.cls = cls;
    want.val = val;
    want.ovf = ovf;
    tok_buf.delete();
    add_text(text);
    if (extra >= 0)
      tok_buf.push_back(8'(extra));
    emit_token(typed, want);
  endtask

  task automatic add_integer_text();
    bit [63:0] v;
    case ($urandom_range(0, 3))
      // straddle the int32 edges, both signs
      0: v = 64'd2147483638 + 64'($urandom_range(0, 20));
      1: begin
        if ($urandom_range(0, 3) == 0)
          add_digits($urandom_range(1, 3) - 1 + 1);
        add_digits($urandom_range(1, 12));
        return;
      end
      2: v = {$urandom, $urandom};
      default: v = 64'($urandom_range(0, 999));
    endcase
    add_text($sformatf("%0d", v));
  endtask

  task automatic add_real_text();
    int n;
    add_sign();
    add_digits($urandom_range(0, 4));
    if ($urandom_range(0, 1))
      tok_buf.push_back(nlc_pkg::CH_DOT);
    add_digits($urandom_range(0, 4));
    if ($urandom_range(0, 2) != 0) begin
      tok_buf.push_back($urandom_range(0, 1) ? nlc_pkg::CH_E_LO : nlc_pkg::CH_E_UP);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 4))
          0: tok_buf.push_back(nlc_pkg::CH_PLUS);
          1: tok_buf.push_back(nlc_pkg::CH_MINUS);
          default: add_digits(1);
        endcase
      end
    end
  endtask

  // Mostly well-formed literals with random content; the rest is grammar soup,
  // raw noise, and good literals with one byte corrupted.
  task automatic add_random_token();
    string soup;
    int    n;
    soup = "+-.eE0123456789";
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        add_sign();
        add_integer_text();
      end
      3, 4, 5: add_real_text();
      6: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          tok_buf.push_back(soup[$urandom_range(0, soup.len() - 1)]);
      end
      7: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          tok_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          add_sign();
          add_integer_text();
        end else begin
          add_real_text();
        end
        if (tok_buf.size() != 0)
          tok_buf[$urandom_range(0, tok_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
    endcase
    if (tok_buf.size() == 0)
      add_digits(1);
    emit_token(1'b0, '{cls: nlc_pkg::CLASS_NONE, val: '0, ovf: 1'b0});
  endtask

  task automatic build_stimulus();
    int directed_bytes;
    dir_rows = '{
      // Typed-in rows: int32 edges and past them, zeros, the lone signs, bad bytes, missing digits.
      '{"2147483647",  -1, 1'b1, nlc_pkg::CLASS_INT,  32'h7fff_ffff, 1'b0},
      '{"-2147483648", -1, 1'b1, nlc_pkg::CLASS_INT,  32'h8000_0000, 1'b0},
      '{"2147483648",  -1, 1'b1, nlc_pkg::CLASS_REAL, 32'd0, 1'b1},
      '{"-2147483649", -1, 1'b1, nlc_pkg::CLASS_REAL, 32'd0, 1'b1},
      '{"99999999999999999999", -1, 1'b1, nlc_pkg::CLASS_REAL, 32'd0, 1'b1},
      '{"0",  -1,    1'b1, nlc_pkg::CLASS_INT,  32'd0, 1'b0},
      '{"-0", -1,    1'b1, nlc_pkg::CLASS_INT,  32'd0, 1'b0},
      '{"+",  -1,    1'b1, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"-",  -1,    1'b1, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"",   'h80,  1'b1, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"",   'h00,  1'b1, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"12", 'hff,  1'b1, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"1e", -1,    1'b1, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"e5", -1,    1'b1, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      // Rows checked against the predictor only.
      '{"+7",     -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"1.5",    -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"1e5",    -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"1E+-5-", -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{".5",     -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"5.",     -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"1.2.3",  -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"1e5.0",  -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"--1",    -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"1-2",    -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0},
      '{"7f",     -1, 1'b0, nlc_pkg::CLASS_NONE, 32'd0, 1'b0}
    };
    foreach (dir_rows[i])
      add_row(dir_rows[i].text, dir_rows[i].extra, dir_rows[i].typed,
              dir_rows[i].cls, dir_rows[i].val, dir_rows[i].ovf);
    directed_bytes = byte_stream.size();
    while (byte_stream.size() < directed_bytes + RANDOM_BYTES)
      add_random_token();
  endtask

  // Idle length for either side: mostly none or short, now and then long, and
  // stretches of back-to-back transfers.
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 88)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at each rising edge, before any of this
  // edge's nonblocking updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_item_t  item;
    lit_result_t want;
    lit_result_t predicted;
    bit          done;
    if (!rst) begin
      // Check the result first so a byte taken on this same edge cannot
      // satisfy a spurious result.
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: class %0d value %0d ovf %0b",
                               number_class, int_value, int_overflow));
        end else begin
          want = pending_results.pop_front();
          if (number_class !== want.cls)
            flag_error($sformatf("number_class %0d, expected %0d", number_class, want.cls));
          if (int_value !== want.val)
            flag_error($sformatf("int_value %0d, expected %0d",
                                 int_value, $signed(want.val)));
          if (int_overflow !== want.ovf)
            flag_error($sformatf("int_overflow %0b, expected %0b", int_overflow, want.ovf));
        end
      end
      if (byte_valid && byte_ready) begin
        item = byte_stream[accepted_bytes];
        accepted_bytes++;
        classify_byte(item.ch, item.last, done, predicted);
        if (done)
          pending_results.push_back(item.typed ? item.want : predicted);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: hold ready low for a random stall, then keep it high until a
  // transfer goes through.
  initial begin
    int gap;
    int quiet;
    quiet = 0;
    result_ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = idle_len(quiet);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid)
        @(posedge clk);
    end
  end

  // Byte side: reset, then walk the stream with random gaps between transfers.
  initial begin
    int gap;
    int quiet;
    quiet      = 0;
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    char_byte  <= '0;
    last_byte  <= 1'b0;
    clear_token();
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (byte_stream[i]) begin
      gap = idle_len(quiet);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Keep valid up across back-to-back transfers; only the payload moves.
      byte_valid <= 1'b1;
      char_byte  <= byte_stream[i].ch;
      last_byte  <= byte_stream[i].last;
      @(posedge clk);
      while (!byte_ready)
        @(posedge clk);
    end
    byte_valid <= 1'b0;

    // Drain: every expected result out, then a quiet window for strays.
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
